[hw/rtl/apor_pkg.sv]
// -----------------------------------------------------------------------------
// apor_pkg
// Shared types and constants for the box push-out resolver.
// -----------------------------------------------------------------------------
package apor_pkg;

  // width of each running shift total
  localparam int SHIFT_BITS = 32;

  // running totals and the grounded mark, passed between core and top
  typedef struct packed {
    logic signed [SHIFT_BITS-1:0] x;
    logic signed [SHIFT_BITS-1:0] y;
    logic signed [SHIFT_BITS-1:0] z;
    logic                         ground;
  } totals_t;

endpackage

[hw/rtl/apor_if.sv]
// -----------------------------------------------------------------------------
// apor_if
// Request channels of the resolver: box items in, shift results out.
// -----------------------------------------------------------------------------
interface apor_item_if #(parameter int COORD_BITS = 31);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] max_z;
  logic                         last;

  modport source (
    output valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, last,
    input  ready
  );
  modport sink (
    input  valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, last,
    output ready
  );
endinterface

interface apor_result_if;
  import apor_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SHIFT_BITS-1:0] shift_x;
  logic signed [SHIFT_BITS-1:0] shift_y;
  logic signed [SHIFT_BITS-1:0] shift_z;
  logic                         grounded;

  modport source (
    output valid, shift_x, shift_y, shift_z, grounded,
    input  ready
  );
  modport sink (
    input  valid, shift_x, shift_y, shift_z, grounded,
    output ready
  );
endinterface

[hw/rtl/aabb_push_out_resolver_top.sv]
// -----------------------------------------------------------------------------
// aabb_push_out_resolver_top
// Minimum-axis push-out of a moving box against a stream of obstacle boxes.
// -----------------------------------------------------------------------------
// One item is taken every cycle while input is not held off. A request is
// captured in an input register, and the resolver then updates the kept box,
// the shift totals and the grounded mark from it; an item with last set loads
// the result register at that edge. The update of the kept box is a loop from
// one item to the next and is computed combinationally from the kept box and
// the input register. Input is held off only when a last item is waiting and
// the result register still holds a result that has not been taken.
module aabb_push_out_resolver_top #(
  parameter int COORD_BITS = 31
) (
  input logic           clk,
  input logic           rst,
  apor_item_if.sink     items,
  apor_result_if.source results
);
  import apor_pkg::*;

  // input register
  logic                         q_valid;
  logic                         q_kind;
  logic                         q_last;
  logic signed [COORD_BITS-1:0] q_box [6];

  // kept state
  logic signed [COORD_BITS-1:0] box [6];
  totals_t                      totals;

  // update path
  logic signed [COORD_BITS-1:0] box_hit [6];
  logic signed [COORD_BITS-1:0] box_next [6];
  totals_t                      tot_hit;
  totals_t                      totals_next;
  logic                         out_free;
  logic                         proc;

  // result register
  logic    res_valid;
  totals_t res;

  // handshake
  always_comb begin
    out_free    = !res_valid || results.ready;
    proc        = q_valid && (!q_last || out_free);
    items.ready = !q_valid || proc;
  end

  apor_resolve #(
    .COORD_BITS (COORD_BITS)
  ) u_resolve (
    .box         (box),
    .ob          (q_box),
    .totals      (totals),
    .box_next    (box_hit),
    .totals_next (tot_hit)
  );

  // load or obstacle
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      box_next[k] = q_kind ? box_hit[k] : q_box[k];
    end
    totals_next = q_kind ? tot_hit : '0;
  end

  // capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (items.ready) begin
      q_valid <= items.valid;
    end
    if (items.valid && items.ready) begin
      q_kind   <= items.kind;
      q_last   <= items.last;
      q_box[0] <= items.min_x;
      q_box[1] <= items.min_y;
      q_box[2] <= items.min_z;
      q_box[3] <= items.max_x;
      q_box[4] <= items.max_y;
      q_box[5] <= items.max_z;
    end
  end

  // kept box and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        box[k] <= '0;
      end
      totals <= '0;
    end else if (proc) begin
      box    <= box_next;
      totals <= totals_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc && q_last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (proc && q_last) begin
      res <= totals_next;
    end
  end

  assign results.valid    = res_valid;
  assign results.shift_x  = res.x;
  assign results.shift_y  = res.y;
  assign results.shift_z  = res.z;
  assign results.grounded = res.ground;

endmodule

[hw/rtl/apor_resolve.sv]
// -----------------------------------------------------------------------------
// apor_resolve
// Combinational push-out of the moving box against one obstacle box:
// overlap test, least-magnitude axis choice, saturating box and total update.
// -----------------------------------------------------------------------------
module apor_resolve #(
  parameter int COORD_BITS = 31
) (
  input  logic signed [COORD_BITS-1:0] box [6],
  input  logic signed [COORD_BITS-1:0] ob [6],
  input  apor_pkg::totals_t            totals,
  output logic signed [COORD_BITS-1:0] box_next [6],
  output apor_pkg::totals_t            totals_next
);
  import apor_pkg::*;

  localparam int DW  = COORD_BITS + 1;                       // face distance
  localparam int BW  = COORD_BITS + 2;                       // moved coordinate
  localparam int SW  = ((DW > SHIFT_BITS) ? DW : SHIFT_BITS) + 1;  // total sum

  localparam logic signed [BW-1:0] BOX_MAX = {3'b000, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [BW-1:0] BOX_MIN = {3'b111, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] SH_MAX  =
    {{(SW-SHIFT_BITS+1){1'b0}}, {(SHIFT_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SH_MIN  =
    {{(SW-SHIFT_BITS+1){1'b1}}, {(SHIFT_BITS-1){1'b0}}};

  logic [2:0]             hit;
  logic                   overlap;
  logic signed [DW-1:0]   dist_hi [3];
  logic signed [DW-1:0]   dist_lo [3];
  logic [DW-1:0]          mag_hi  [3];
  logic [DW-1:0]          mag_lo  [3];
  logic signed [DW-1:0]   face_d  [3];
  logic [DW-1:0]          mag     [3];
  logic [1:0]             axis;
  logic signed [DW-1:0]   d_sel;
  logic signed [BW-1:0]   moved   [6];
  logic signed [SW-1:0]   tot_cur;
  logic signed [SW-1:0]   tot_sum;
  logic signed [SHIFT_BITS-1:0] tot_sat;

  // per-axis overlap and the smaller of the two face distances
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hit[i]     = (box[i] <= ob[i+3]) && (box[i+3] >= ob[i]);
      dist_hi[i] = DW'(ob[i+3]) - DW'(box[i]);
      dist_lo[i] = DW'(ob[i]) - DW'(box[i+3]);
      mag_hi[i]  = dist_hi[i][DW-1] ? DW'(-dist_hi[i]) : DW'(dist_hi[i]);
      mag_lo[i]  = dist_lo[i][DW-1] ? DW'(-dist_lo[i]) : DW'(dist_lo[i]);
      if (mag_hi[i] < mag_lo[i]) begin
        face_d[i] = dist_hi[i];
        mag[i]    = mag_hi[i];
      end else begin
        face_d[i] = dist_lo[i];
        mag[i]    = mag_lo[i];
      end
    end
    overlap = &hit;
  end

  // least magnitude wins, ties go x, y, z
  always_comb begin
    if (mag[0] <= mag[1] && mag[0] <= mag[2]) begin
      axis = 2'd0;
    end else if (mag[1] <= mag[2]) begin
      axis = 2'd1;
    end else begin
      axis = 2'd2;
    end
    d_sel = face_d[axis];
  end

  // on overlap, move the box on the chosen axis, saturating each face
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      moved[k]    = BW'(box[k]) + BW'(d_sel);
      box_next[k] = box[k];
      if (overlap && (k % 3) == int'(axis)) begin
        if (moved[k] > BOX_MAX) begin
          box_next[k] = BOX_MAX[COORD_BITS-1:0];
        end else if (moved[k] < BOX_MIN) begin
          box_next[k] = BOX_MIN[COORD_BITS-1:0];
        end else begin
          box_next[k] = moved[k][COORD_BITS-1:0];
        end
      end
    end
  end

  // on overlap, saturating add to the running total of the chosen axis and grounded mark
  always_comb begin
    case (axis)
      2'd0:    tot_cur = SW'(totals.x);
      2'd1:    tot_cur = SW'(totals.y);
      default: tot_cur = SW'(totals.z);
    endcase
    tot_sum = tot_cur + SW'(d_sel);
    if (tot_sum > SH_MAX) begin
      tot_sat = SH_MAX[SHIFT_BITS-1:0];
    end else if (tot_sum < SH_MIN) begin
      tot_sat = SH_MIN[SHIFT_BITS-1:0];
    end else begin
      tot_sat = tot_sum[SHIFT_BITS-1:0];
    end

    totals_next = totals;
    if (overlap) begin
      // grounded is judged before the box moves
      if (ob[2] < box[5]) begin
        totals_next.ground = 1'b1;
      end
      case (axis)
        2'd0:    totals_next.x = tot_sat;
        2'd1:    totals_next.y = tot_sat;
        default: totals_next.z = tot_sat;
      endcase
    end
  end

endmodule

[dv/push_out_checker.sv]
// -----------------------------------------------------------------------------
// push_out_checker
// Watches both channels of the box push-out resolver, keeps its own copy of
// the kept box, shift totals and grounded mark, and compares every result
// against the oldest predicted totals.
// -----------------------------------------------------------------------------
module push_out_checker #(
  parameter int COORD_BITS = 31
) (
  input  logic   clk,
  input  logic   rst,
  apor_item_if   items,
  apor_result_if results,
  output int     fail_count,
  output int     pending,
  output int     results_checked,
  output int     contacts,
  output int     grounded_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import apor_pkg::*;

  localparam longint C_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint C_LO = -C_HI - 1;
  localparam longint S_HI = 64'sd2147483647;
  localparam longint S_LO = -64'sd2147483648;

  // predicted block state: min x/y/z then max x/y/z
  longint  box_pos [6];
  longint  shift_acc [3];
  bit      ground_flag;
  totals_t totals_due [$];

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // smaller-magnitude face distance; equal magnitudes keep the second
  function automatic longint nearer_face(input longint a, input longint b);
    return (mag(a) < mag(b)) ? a : b;
  endfunction

  // inclusive overlap test and minimum-axis push of the kept box
  function automatic void apply_obstacle(input longint ob [6]);
    longint d [3];
    int     ax;
    for (int i = 0; i < 3; i++)
      if (!(box_pos[i] <= ob[i+3] && box_pos[i+3] >= ob[i])) return;
    for (int i = 0; i < 3; i++)
      d[i] = nearer_face(ob[i+3] - box_pos[i], ob[i] - box_pos[i+3]);
    if (mag(d[0]) <= mag(d[1]) && mag(d[0]) <= mag(d[2])) ax = 0;
    else if (mag(d[1]) <= mag(d[2])) ax = 1;
    else ax = 2;
    contacts++;
    // floor test uses the box before it moves
    if (ob[2] - box_pos[5] < 0) ground_flag = 1'b1;
    box_pos[ax]     = sat(box_pos[ax] + d[ax], C_LO, C_HI);
    box_pos[ax+3]   = sat(box_pos[ax+3] + d[ax], C_LO, C_HI);
    shift_acc[ax]   = sat(shift_acc[ax] + d[ax], S_LO, S_HI);
  endfunction

  function automatic void match_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    totals_t want;
    longint  ob [6];
    if (rst) begin
      for (int i = 0; i < 6; i++) box_pos[i] = 0;
      for (int i = 0; i < 3; i++) shift_acc[i] = 0;
      ground_flag = 1'b0;
      totals_due.delete();
      pending <= 0;
    end else begin
      // result side first: a result never belongs to a request of this edge
      if (results.valid && results.ready) begin
        if (totals_due.size() == 0) begin
          $error("unexpected result: shift_x %0d shift_y %0d shift_z %0d grounded %0b",
                 results.shift_x, results.shift_y, results.shift_z, results.grounded);
          fail_count++;
        end else begin
          want = totals_due.pop_front();
          match_field("shift_x", want.x, results.shift_x);
          match_field("shift_y", want.y, results.shift_y);
          match_field("shift_z", want.z, results.shift_z);
          match_field("grounded", {31'b0, want.ground}, {31'b0, results.grounded});
          results_checked++;
        end
      end
      // request side
      if (items.valid && items.ready) begin
        ob[0] = longint'(items.min_x);
        ob[1] = longint'(items.min_y);
        ob[2] = longint'(items.min_z);
        ob[3] = longint'(items.max_x);
        ob[4] = longint'(items.max_y);
        ob[5] = longint'(items.max_z);
        if (items.kind == 1'b0) begin
          for (int i = 0; i < 6; i++) box_pos[i] = ob[i];
          for (int i = 0; i < 3; i++) shift_acc[i] = 0;
          ground_flag = 1'b0;
        end else begin
          apply_obstacle(ob);
        end
        if (items.last) begin
          want.x      = shift_acc[0][31:0];
          want.y      = shift_acc[1][31:0];
          want.z      = shift_acc[2][31:0];
          want.ground = ground_flag;
          if (ground_flag) grounded_results++;
          totals_due.push_back(want);
        end
      end
      pending <= totals_due.size();
    end
  end

endmodule

[dv/tb_top.sv]
// -----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the box push-out resolver: a directed opening on
// extremes, ties, touching faces and inverted boxes, then random frames of
// one load and one to six obstacles, mixed with unstructured requests, under three idling regimes.
// -----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CB    = 31;
  localparam longint C_HI  = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint C_LO  = -C_HI - 1;
  localparam int     LIMIT = 400000;
  localparam bit     LOAD  = 1'b0;
  localparam bit     OBST  = 1'b1;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   reqs_sent;
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   results_checked;
  int   contacts;
  int   grounded_results;

  apor_item_if #(.COORD_BITS(CB)) item_ch ();
  apor_result_if                  result_ch ();

  aabb_push_out_resolver_top #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch)
  );

  push_out_checker #(.COORD_BITS(CB)) chk (
    .clk              (clk),
    .rst              (rst),
    .items            (item_ch),
    .results          (result_ch),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .contacts         (contacts),
    .grounded_results (grounded_results)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic longint clip(input longint v);
    return (v < C_LO) ? C_LO : ((v > C_HI) ? C_HI : v);
  endfunction

  function automatic longint rand_coord();
    logic [CB-1:0] r;
    r = CB'($urandom);
    return longint'($signed(r));
  endfunction

  // one request, with random idle cycles in front of it
  task automatic send_req(input bit kind, input longint mnx, input longint mny,
                          input longint mnz, input longint mxx, input longint mxy,
                          input longint mxz, input bit last);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind  <= kind;
    item_ch.min_x <= mnx[CB-1:0];
    item_ch.min_y <= mny[CB-1:0];
    item_ch.min_z <= mnz[CB-1:0];
    item_ch.max_x <= mxx[CB-1:0];
    item_ch.max_y <= mxy[CB-1:0];
    item_ch.max_z <= mxz[CB-1:0];
    item_ch.last  <= last;
    do @(posedge clk); while (!item_ch.ready);
    reqs_sent++;
  endtask

  task automatic send_box(input bit kind, input longint c [6], input bit last);
    send_req(kind, c[0], c[1], c[2], c[3], c[4], c[5], last);
  endtask

  // sender holds off until every predicted result has been taken
  task automatic drain_wait();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // load, then obstacles built to overlap the loaded box
  task automatic play_frame();
    longint b [6];
    longint o [6];
    longint reach;
    longint ctr;
    longint half;
    longint t;
    int     n;
    int     a;
    case ($urandom_range(5))
      0:       reach = 4;
      1:       reach = 256;
      2:       reach = 4096;
      3:       reach = 1 << 20;
      4:       reach = 1 << 27;
      default: reach = 1 << 29;
    endcase
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(5))
        0:       ctr = C_HI - longint'($urandom_range(32'(reach)));
        1:       ctr = C_LO + longint'($urandom_range(32'(reach)));
        default: ctr = rand_coord() / 2;
      endcase
      half   = longint'($urandom_range(32'(reach)));
      b[i]   = clip(ctr - half);
      b[i+3] = clip(ctr + half);
    end
    if ($urandom_range(19) == 0) begin
      a = $urandom_range(2);
      t = b[a];
      b[a] = b[a+3];
      b[a+3] = t;
    end
    n = $urandom_range(1, 6);
    send_box(LOAD, b, $urandom_range(9) == 0);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(9) == 0) begin
          o[i]   = rand_coord();
          o[i+3] = rand_coord();
        end else begin
          o[i]   = clip(b[i+3] - longint'($urandom_range(32'(3 * reach))));
          o[i+3] = clip(b[i] + longint'($urandom_range(32'(3 * reach))));
        end
      end
      // floor flush with the box top: contact without grounding
      if ($urandom_range(6) == 0) o[2] = b[5];
      if ($urandom_range(19) == 0) begin
        a = $urandom_range(2);
        t = o[a];
        o[a] = o[a+3];
        o[a+3] = t;
      end
      send_box(OBST, o, (k == n - 1) || ($urandom_range(7) == 0));
    end
  endtask

  // unstructured requests
  task automatic play_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_req(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
  endtask

  initial begin
    int target;
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.kind  <= LOAD;
    item_ch.min_x <= '0;
    item_ch.min_y <= '0;
    item_ch.min_z <= '0;
    item_ch.max_x <= '0;
    item_ch.max_y <= '0;
    item_ch.max_z <= '0;
    item_ch.last  <= 1'b0;
    send_idle = 33;
    recv_idle = 72;
    reqs_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // obstacle before any load hits the all-zero reset box
    send_req(OBST, -256, -256, -256, 256, 256, 256, 1'b1);
    // miss; totals survive the previous result
    send_req(OBST, 0, 0, 0, 0, 0, 0, 1'b1);
    // load with last returns cleared totals
    send_req(LOAD, 100, 200, 300, 400, 500, 600, 1'b1);
    // y and z tie, y wins
    send_req(OBST, 0, 450, 550, 1000, 1000, 1000, 1'b0);
    // equal face distances on x, second face taken
    send_req(OBST, 250, 0, 0, 250, 600, 1000, 1'b1);
    // touching face gives a zero push
    send_req(OBST, -500, -1000, -1000, -50, 1000, 1000, 1'b1);
    // floor flush with box top: no grounding
    send_req(LOAD, 0, 0, 0, 1000, 1000, 1000, 1'b0);
    send_req(OBST, -5000, -5000, 1000, 5000, 5000, 5000, 1'b1);
    // inverted kept box: one miss, one hit
    send_req(LOAD, 500, 0, 0, -500, 1000, 1000, 1'b0);
    send_req(OBST, -100, 100, 100, 100, 900, 900, 1'b1);
    send_req(OBST, -1000, 100, 100, 1000, 900, 900, 1'b1);
    // inverted obstacle
    send_req(OBST, 100, 100, 100, -100, 900, 900, 1'b1);
    send_req(LOAD, -1000, -1000, -1000, 1000, 1000, 1000, 1'b0);
    send_req(OBST, 200, -500, -500, -200, 500, 500, 1'b1);
    // full-range boxes: kept box saturates low, then a zero push
    send_req(LOAD, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b0);
    send_req(OBST, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b1);
    send_req(OBST, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b1);
    // large positive pushes, box max saturates, x total reaches the top
    send_req(LOAD, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b0);
    send_req(OBST, C_LO, C_LO, C_LO, C_HI - 2, C_HI, C_HI, 1'b0);
    send_req(OBST, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI, 1'b1);
    // z push down from the top of the range
    send_req(LOAD, 0, 0, C_HI - 10, 100, 100, C_HI, 1'b0);
    send_req(OBST, -1000, -1000, C_HI - 4, 1000, 1000, C_HI, 1'b1);
    drain_wait();

    // random frames under three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle = 33; recv_idle = 72; end
        1:       begin send_idle = 72; recv_idle = 33; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      target = reqs_sent + 176;
      while (reqs_sent < target) begin
        if ($urandom_range(99) < 15) play_noise();
        else play_frame();
      end
      drain_wait();
    end

    repeat (10) @(posedge clk);
    $display("Summary: %0d requests driven, %0d results checked", reqs_sent, results_checked);
    $display("Summary: %0d obstacle contacts, %0d grounded results", contacts,
             grounded_results);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
